FILE: hw/rtl/arpc_pkg.sv
// Package for the ARP cache next-hop resolver: payload structs, the probe
// and write-back structs of the cell chain, and fixed codes. No dependencies.
package arpc_pkg;

	localparam logic        MODE_LEARN   = 1'b0;
	localparam logic        MODE_RESOLVE = 1'b1;
	localparam logic [31:0] IP_BROADCAST = 32'hFFFF_FFFF;
	localparam logic [47:0] MAC_ALL_ONES = 48'hFFFF_FFFF_FFFF;

	localparam int          CFG_IDX_W     = 2;
	localparam logic [1:0]  CFG_OWN_IP    = 2'd0;
	localparam logic [1:0]  CFG_SUBNET    = 2'd1;
	localparam logic [1:0]  CFG_ROUTER_IP = 2'd2;

	typedef struct packed {
		logic        mode;
		logic [31:0] ip_addr;
		logic [47:0] mac_in;
	} req_t;

	typedef struct packed {
		logic        hit;
		logic [47:0] mac_out;
		logic [31:0] next_hop_ip;
		logic        via_router;
	} rsp_t;

	// Search token walking the cell chain, one cell per cycle.
	typedef struct packed {
		logic        valid;
		logic [31:0] key;
		logic        found;
		logic [47:0] mac;
		logic        free_seen;
	} probe_t;

	typedef enum logic [1:0] {
		WB_MATCH   = 2'd0,
		WB_FREE    = 2'd1,
		WB_REPLACE = 2'd2
	} wb_sel_t;

	// Write-back command broadcast to all cells.
	typedef struct packed {
		logic        en;
		wb_sel_t     sel;
		logic [31:0] ip;
		logic [47:0] mac;
	} wb_t;

endpackage

FILE: hw/rtl/arpc_cell.sv
// One table entry of the ARP cache plus its stage of the search chain.
// Depends on arpc_pkg.
module arpc_cell
	import arpc_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  probe_t probe_in,
	output probe_t probe_out,
	input  wb_t    wb,
	input  logic   rp_here
);

	logic        valid_q;
	logic [31:0] ip_q;
	logic [47:0] mac_q;
	logic        match_q;
	logic        free_q;
	probe_t      probe_q;
	probe_t      probe_nxt;
	logic        is_match;
	logic        is_free;
	logic        wr;

	assign is_match = probe_in.valid && !probe_in.found && valid_q && (ip_q == probe_in.key);
	assign is_free  = probe_in.valid && !probe_in.free_seen && !valid_q;

	always_comb begin
		probe_nxt = probe_in;
		if (is_match) begin
			probe_nxt.found = 1'b1;
			probe_nxt.mac   = mac_q;
		end
		if (probe_in.valid && !valid_q) begin
			probe_nxt.free_seen = 1'b1;
		end
	end

	always_comb begin
		wr = 1'b0;
		if (wb.en) begin
			unique case (wb.sel)
				WB_MATCH:   wr = match_q;
				WB_FREE:    wr = free_q;
				WB_REPLACE: wr = rp_here;
				default:    wr = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			match_q <= 1'b0;
			free_q  <= 1'b0;
			probe_q <= '0;
		end else begin
			probe_q <= probe_nxt;
			if (probe_in.valid) begin
				match_q <= is_match;
				free_q  <= is_free;
			end
			if (wr) begin
				valid_q <= 1'b1;
			end
		end
	end

	// Entry contents: no reset needed
	always_ff @(posedge clk) begin
		if (wr) begin
			ip_q  <= wb.ip;
			mac_q <= wb.mac;
		end
	end

	assign probe_out = probe_q;

endmodule

FILE: hw/rtl/arp_cache_next_hop_resolver.sv
// ARP cache next-hop resolver, top level. A transferred request's search token
// is registered at the chain head, walks every cell, and its result is registered.
// One request at a time: the search token walks the cell chain one entry per
// cycle and a new request waits until the result reaches the output register.
// Reset clears all entry valid bits, the replace pointer and the config regs.
// Depends on arpc_pkg and arpc_cell.
module arp_cache_next_hop_resolver
	import arpc_pkg::*;
#(
	parameter int TABLE_ENTRIES = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// request channel
	input  logic                 req_valid,
	output logic                 req_stall,
	input  req_t                 req,
	// response channel
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output rsp_t                 rsp,
	// config write port
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [31:0]          cfg_wdata
);

	localparam int PTR_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(TABLE_ENTRIES - 1);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SEARCH = 3'b010,
		ST_DONE   = 3'b100
	} state_t;

	state_t state_q;

	// config registers
	logic [31:0] own_ip_q;
	logic [31:0] subnet_mask_q;
	logic [31:0] router_ip_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_ip_q      <= '0;
			subnet_mask_q <= '0;
			router_ip_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_OWN_IP:    own_ip_q      <= cfg_wdata;
				CFG_SUBNET:    subnet_mask_q <= cfg_wdata;
				CFG_ROUTER_IP: router_ip_q   <= cfg_wdata;
				default:       ;  // unmapped index, write dropped
			endcase
		end
	end

	// Request decode at transfer time: broadcast takes priority over the
	// subnet test; off-subnet destinations resolve through the router.
	logic        req_xfer;
	logic        req_bcast;
	logic        req_off_net;
	logic        req_via;
	logic [31:0] req_hop;

	assign req_xfer    = req_valid && !req_stall;
	assign req_stall   = (state_q != ST_IDLE);
	assign req_bcast   = (req.mode == MODE_RESOLVE) && (req.ip_addr == IP_BROADCAST);
	assign req_off_net = (req.ip_addr & subnet_mask_q) != (own_ip_q & subnet_mask_q);
	assign req_via     = (req.mode == MODE_RESOLVE) && !req_bcast && req_off_net;
	assign req_hop     = req_via ? router_ip_q : req.ip_addr;

	logic        mode_q;
	logic        bcast_q;
	logic        via_q;
	logic [31:0] hop_q;
	logic [47:0] mac_q;

	always_ff @(posedge clk) begin
		if (req_xfer) begin
			mode_q  <= req.mode;
			bcast_q <= req_bcast;
			via_q   <= req_via;
			hop_q   <= req_hop;
			mac_q   <= req.mac_in;
		end
	end

	// Token injection into the head of the chain, in the cycle after transfer
	probe_t inj_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inj_q <= '0;
		end else begin
			inj_q.valid     <= req_xfer;
			inj_q.key       <= req_hop;
			inj_q.found     <= 1'b0;
			inj_q.mac       <= '0;
			inj_q.free_seen <= 1'b0;
		end
	end

	// Cell chain. Lowest index sees the token first, so the first match
	// and the first free slot are the lowest-numbered ones.
	probe_t                 chain [TABLE_ENTRIES+1];
	probe_t                 chain_end;
	logic [TABLE_ENTRIES-1:0] tok_vec;
	logic [PTR_W-1:0]       rp_q;
	wb_t                    wb;

	assign chain[0]  = inj_q;
	assign chain_end = chain[TABLE_ENTRIES];

	for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
		logic rp_here;
		assign rp_here    = (rp_q == PTR_W'(i));
		assign tok_vec[i] = chain[i+1].valid;

		arpc_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.probe_in  (chain[i]),
			.probe_out (chain[i+1]),
			.wb        (wb),
			.rp_here   (rp_here)
		);
	end

	// For learn requests, write-back fires the cycle the token leaves the chain;
	// by then every cell holds its match and first-free flags for this request.
	logic search_end;

	assign search_end = (state_q == ST_SEARCH) && chain_end.valid;

	always_comb begin
		wb.en  = search_end && (mode_q == MODE_LEARN);
		wb.ip  = hop_q;
		wb.mac = mac_q;
		if (chain_end.found) begin
			wb.sel = WB_MATCH;
		end else if (chain_end.free_seen) begin
			wb.sel = WB_FREE;
		end else begin
			wb.sel = WB_REPLACE;
		end
	end

	// Round-robin pointer moves only when a valid entry is evicted
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q <= '0;
		end else if (wb.en && (wb.sel == WB_REPLACE)) begin
			rp_q <= (rp_q == PTR_LAST) ? '0 : rp_q + PTR_W'(1);
		end
	end

	// Result assembly
	rsp_t res_nxt;
	rsp_t res_q;

	always_comb begin
		res_nxt.next_hop_ip = hop_q;
		res_nxt.via_router  = via_q;
		if (mode_q == MODE_LEARN) begin
			res_nxt.hit     = chain_end.found;
			res_nxt.mac_out = '0;
		end else if (bcast_q) begin
			res_nxt.hit     = 1'b1;
			res_nxt.mac_out = MAC_ALL_ONES;
		end else begin
			res_nxt.hit     = chain_end.found;
			res_nxt.mac_out = chain_end.found ? chain_end.mac : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (search_end) begin
			res_q <= res_nxt;
		end
	end

	// Output register; the response waits here while the next request
	// can already be taken.
	logic rsp_valid_q;
	rsp_t rsp_q;
	logic rsp_free;

	assign rsp_free = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			// a new result loads in the same edge the old one transfers
			if ((state_q == ST_DONE) && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_xfer) begin
						state_q <= ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					if (chain_end.valid) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (rsp_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && rsp_free) begin
			rsp_q <= res_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Only one search token is ever in flight along the chain.
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_vec))
		else $error("more than one search token in the chain");

	// The token leaves the chain only while a search is pending.
	a_end_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		chain_end.valid |-> (state_q == ST_SEARCH))
		else $error("search token left the chain outside a search");

	// Table writes come only from learn requests.
	a_wb_learn: assert property (@(posedge clk) disable iff (!arst_n)
		wb.en |-> (mode_q == MODE_LEARN))
		else $error("table write-back during a resolve");

	// A finished search always moves on to the result stage, never skipped.
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		search_end |=> (state_q == ST_DONE))
		else $error("search finished without entering result stage");

endmodule
